// ===== rtl/fht_pkg.sv =====
// Shared types and constants for the forwarding hash table.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none

package fht_pkg;

  localparam int unsigned SLOTS_DEF  = 1024;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned PCT        = 100;
  localparam int unsigned HASH_SHIFT = 3;
  localparam int unsigned ENTRY_W    = 1 + 2 * KEY_W;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd75;
  localparam logic [KEY_W-1:0]   ALL_ONES  = '1;

  // Register index, taken from paddr bit 2.
  localparam logic REG_LOAD_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_PROBE,
    S_CLEAR
  } state_e;

  typedef struct packed {
    logic    load;
    logic    rd_home;
    logic    rd_next;
    logic    wr_entry;
    logic    wr_clear;
    logic    clr_start;
    logic    clr_step;
    logic    cnt_inc;
    logic    cnt_clear;
    logic    resp;
    logic    hit;
    status_e resp_status;
  } cmd_t;

  typedef struct packed {
    logic over_limit;
    logic key_reserved;
    logic slot_used;
    logic key_match;
    logic probe_last;
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/fht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used by the hash table datapath for the slot store.
`default_nettype none

module fht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/fht_ctrl.sv =====
// Controller state machine for the forwarding hash table.
// Depends on fht_pkg; drives datapath commands from datapath status.
`default_nettype none

module fht_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [1:0]   opcode_i,
  input  wire fht_pkg::sts_t sts_i,
  output fht_pkg::cmd_t     cmd_o,
  output logic              busy_o
);

  fht_pkg::state_e state_q, state_d;
  fht_pkg::op_e    op_q, op_d;
  fht_pkg::op_e    op_in;

  assign op_in = fht_pkg::op_e'(opcode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fht_pkg::S_INIT;
      op_q    <= fht_pkg::OP_NOP;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    case (state_q)
      fht_pkg::S_INIT: begin
        cmd_o.wr_clear = 1'b1;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = fht_pkg::S_IDLE;
        end
      end
      fht_pkg::S_IDLE: begin
        if (start_i) begin
          op_d = op_in;
          case (op_in)
            fht_pkg::OP_LOOKUP: begin
              if (sts_i.key_reserved) begin
                cmd_o.resp        = 1'b1;
                cmd_o.resp_status = fht_pkg::ST_MISS;
              end else begin
                cmd_o.load    = 1'b1;
                cmd_o.rd_home = 1'b1;
                state_d       = fht_pkg::S_PROBE;
              end
            end
            fht_pkg::OP_INSERT: begin
              if (sts_i.over_limit) begin
                cmd_o.resp        = 1'b1;
                cmd_o.resp_status = fht_pkg::ST_FULL;
              end else if (sts_i.key_reserved) begin
                cmd_o.resp        = 1'b1;
                cmd_o.resp_status = fht_pkg::ST_MISS;
              end else begin
                cmd_o.load    = 1'b1;
                cmd_o.rd_home = 1'b1;
                state_d       = fht_pkg::S_PROBE;
              end
            end
            fht_pkg::OP_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              cmd_o.cnt_clear = 1'b1;
              state_d         = fht_pkg::S_CLEAR;
            end
            default: begin
              cmd_o.resp        = 1'b1;
              cmd_o.resp_status = fht_pkg::ST_OK;
            end
          endcase
        end
      end
      fht_pkg::S_PROBE: begin
        if (!sts_i.slot_used) begin
          cmd_o.resp = 1'b1;
          state_d    = fht_pkg::S_IDLE;
          if (op_q == fht_pkg::OP_INSERT) begin
            cmd_o.wr_entry    = 1'b1;
            cmd_o.cnt_inc     = 1'b1;
            cmd_o.resp_status = fht_pkg::ST_OK;
          end else begin
            cmd_o.resp_status = fht_pkg::ST_MISS;
          end
        end else if (sts_i.key_match) begin
          cmd_o.resp        = 1'b1;
          cmd_o.resp_status = fht_pkg::ST_OK;
          state_d           = fht_pkg::S_IDLE;
          if (op_q == fht_pkg::OP_INSERT) begin
            cmd_o.wr_entry = 1'b1;
          end else begin
            cmd_o.hit = 1'b1;
          end
        end else if (sts_i.probe_last) begin
          cmd_o.resp = 1'b1;
          state_d    = fht_pkg::S_IDLE;
          if (op_q == fht_pkg::OP_INSERT) begin
            cmd_o.resp_status = fht_pkg::ST_FULL;
          end else begin
            cmd_o.resp_status = fht_pkg::ST_MISS;
          end
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      fht_pkg::S_CLEAR: begin
        cmd_o.wr_clear = 1'b1;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.resp        = 1'b1;
          cmd_o.resp_status = fht_pkg::ST_OK;
          state_d           = fht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fht_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != fht_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/fht_dp.sv =====
// Datapath for the forwarding hash table: slot RAM, probe address, entry
// count, load limit register and result register. Depends on fht_pkg, fht_ram.
`default_nettype none

module fht_dp #(
  parameter int unsigned SLOTS = fht_pkg::SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fht_pkg::cmd_t                 cmd_i,
  output wire fht_pkg::sts_t                 sts_o,
  input  wire logic [fht_pkg::KEY_W-1:0]     old_offset_i,
  input  wire logic [fht_pkg::KEY_W-1:0]     new_offset_i,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [fht_pkg::PADDR_W-1:0]   paddr_i,
  input  wire logic [fht_pkg::PDATA_W-1:0]   pwdata_i,
  output logic      [fht_pkg::PDATA_W-1:0]   prdata_o,
  output logic      [fht_pkg::KEY_W-1:0]     mapped_offset_o,
  output logic      [1:0]                    status_o,
  output logic                               done_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned PW = CW + fht_pkg::LIMIT_W;
  localparam int unsigned KW = fht_pkg::KEY_W;

  logic [AW-1:0]                h_q, h_d, home;
  logic [AW-1:0]                n_q, n_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [fht_pkg::LIMIT_W-1:0]  limit_q;
  logic [KW-1:0]                key_q, val_q;
  logic [KW-1:0]                mapped_q;
  logic [1:0]                   status_q;
  logic                         done_q;
  logic [PW-1:0]                used_pct;
  logic [PW-2:0]                limit_pct;
  logic                         ram_we;
  logic [AW-1:0]                ram_raddr;
  logic [fht_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic                         cfg_we;

  assign home = old_offset_i[fht_pkg::HASH_SHIFT +: AW];

  always_comb begin
    h_d = h_q;
    n_d = n_q;
    if (cmd_i.load) begin
      h_d = home;
      n_d = '0;
    end else if (cmd_i.clr_start) begin
      h_d = '0;
    end else if (cmd_i.rd_next || cmd_i.clr_step) begin
      h_d = h_q + AW'(1);
      if (cmd_i.rd_next) begin
        n_d = n_q + AW'(1);
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clear) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  assign cfg_we = psel_i && penable_i && pwrite_i &&
                  (paddr_i[2] == fht_pkg::REG_LOAD_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q     <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
      limit_q <= fht_pkg::LIMIT_RST;
      done_q  <= 1'b0;
    end else begin
      h_q    <= h_d;
      n_q    <= n_d;
      cnt_q  <= cnt_d;
      done_q <= cmd_i.resp;
      if (cfg_we) begin
        limit_q <= pwdata_i[fht_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= old_offset_i;
      val_q <= new_offset_i;
    end
    if (cmd_i.resp) begin
      status_q <= cmd_i.resp_status;
      mapped_q <= cmd_i.hit ? ram_rdata[KW-1:0] : fht_pkg::ALL_ONES;
    end
  end

  assign ram_we    = cmd_i.wr_entry || cmd_i.wr_clear;
  assign ram_wdata = cmd_i.wr_entry ? {1'b1, key_q, val_q} : '0;
  assign ram_raddr = cmd_i.rd_home ? home : (h_q + AW'(1));

  fht_ram #(
    .WIDTH (fht_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (h_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_home || cmd_i.rd_next),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Refuse inserts once entry_count * 100 >= 2**AW * limit (SLOTS * limit when SLOTS is a power of two).
  assign used_pct  = {{fht_pkg::LIMIT_W{1'b0}}, cnt_q} * PW'(fht_pkg::PCT);
  assign limit_pct = {limit_q, {AW{1'b0}}};

  assign sts_o.over_limit   = (used_pct >= {1'b0, limit_pct});
  assign sts_o.key_reserved = (old_offset_i == fht_pkg::ALL_ONES);
  assign sts_o.slot_used    = ram_rdata[fht_pkg::ENTRY_W-1];
  assign sts_o.key_match    = (ram_rdata[2*KW-1:KW] == key_q);
  assign sts_o.probe_last   = (n_q == AW'(SLOTS - 1));
  assign sts_o.clr_last     = (h_q == AW'(SLOTS - 1));

  assign prdata_o = (paddr_i[2] == fht_pkg::REG_LOAD_LIMIT) ?
                    {{(fht_pkg::PDATA_W - fht_pkg::LIMIT_W){1'b0}}, limit_q} : '0;

  assign mapped_offset_o = mapped_q;
  assign status_o        = status_q;
  assign done_o          = done_q;

endmodule

`default_nettype wire

// ===== rtl/forwarding_hash_table.sv =====
// Top level of the forwarding hash table: controller plus datapath.
// Depends on fht_pkg, fht_ctrl, fht_dp (and fht_ram below it).
//
//   channel   handshake                       words
//   command   start / busy                    opcode_i, old_offset_i, new_offset_i
//   result    done_o (one-cycle strobe)       mapped_offset_o, status_o
//   config    APB psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// A lookup or insert holds busy while it probes slots in turn; the slot
// RAM's single read port reads one slot per cycle.
// Reserved keys, refused inserts and opcode 3 never raise busy.
// A clear sweeps the RAM one slot per cycle.
// After reset the same sweep runs before start is taken.
// The result strobe follows the last busy cycle; the receiver cannot stall.
`default_nettype none

module forwarding_hash_table #(
  parameter int unsigned SLOTS = fht_pkg::SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [fht_pkg::KEY_W-1:0]     old_offset_i,
  input  wire logic [fht_pkg::KEY_W-1:0]     new_offset_i,
  output logic                               done_o,
  output logic      [fht_pkg::KEY_W-1:0]     mapped_offset_o,
  output logic      [1:0]                    status_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fht_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [fht_pkg::PDATA_W-1:0]   pwdata,
  output logic      [fht_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  fht_pkg::cmd_t cmd;
  fht_pkg::sts_t sts;

  fht_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  fht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .old_offset_i    (old_offset_i),
    .new_offset_i    (new_offset_i),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .mapped_offset_o (mapped_offset_o),
    .status_o        (status_o),
    .done_o          (done_o)
  );

  assign pready = 1'b1;

  // A result is only ever issued while the controller is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // A failed command never carries a mapped value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != fht_pkg::ST_OK)) |-> (mapped_offset_o == fht_pkg::ALL_ONES))
    else $error("mapped offset set on a non-ok result");

  // A clear always sweeps the table before answering.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == fht_pkg::OP_CLEAR)) |=> (busy && !done_o))
    else $error("clear answered without a sweep");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == fht_pkg::ST_OK || status_o == fht_pkg::ST_MISS ||
                status_o == fht_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

`default_nettype wire
